/* src/emc_pkg.sv */
package emc_pkg;

   // Reset values and limits of the configuration registers.
   localparam logic [6:0]  PowerMax       = 7'd100;
   localparam logic [6:0]  PowerLimitRst  = 7'd100;
   localparam logic [15:0] StallWindowRst = 16'd250;
   localparam logic [15:0] MoveTimeoutRst = 16'd2000;

   // Largest goal magnitude; the most negative target saturates to it.
   localparam logic [14:0] GoalMax = 15'h7fff;

   localparam logic CMD_START  = 1'b0;
   localparam logic CMD_SAMPLE = 1'b1;

   // Bumper bit positions.
   localparam int BUMP_RIGHT_REAR  = 0;
   localparam int BUMP_LEFT_REAR   = 1;
   localparam int BUMP_RIGHT_FRONT = 2;
   localparam int BUMP_LEFT_FRONT  = 3;

   typedef enum logic [1:0] {
      CSR_POWER_LIMIT  = 2'd0,
      CSR_STALL_WINDOW = 2'd1,
      CSR_MOVE_TIMEOUT = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_MOVING  = 3'd0,
      ST_REACHED = 3'd1,
      ST_STOPPED = 3'd2,
      ST_ABORTED = 3'd3,
      ST_TIMEOUT = 3'd4,
      ST_IDLE    = 3'd5
   } status_type;

   typedef struct packed {
      logic [6:0]  power_limit;
      logic [15:0] stall_window_ms;
      logic [15:0] move_timeout_ms;
   } cfg_type;

   typedef struct packed {
      logic               cmd;
      logic signed [15:0] target_left;
      logic signed [15:0] target_right;
      logic               force_req;
      logic [15:0]        enc_left;
      logic [15:0]        enc_right;
      logic [3:0]         bumpers;
      logic [31:0]        now_ms;
      logic               stop_request;
   } item_type;

   typedef struct packed {
      logic signed [7:0] power_left;
      logic signed [7:0] power_right;
      status_type        status;
      logic              stalled;
      logic              blocked;
      logic [3:0]        block_mask;
   } result_type;

   // True once now has reached the deadline, modulo 2^32 wrap.
   function automatic logic time_reached(input logic [31:0] now, input logic [31:0] deadline);
      logic [31:0] diff;
      diff = now - deadline;
      return ~diff[31];
   endfunction

   // Three quarters of a signed power, rounded toward zero.
   function automatic logic signed [7:0] three_quarters(input logic signed [7:0] p);
      logic [7:0] mag;
      logic [9:0] mag3;
      logic [7:0] q;
      mag  = p[7] ? 8'(-p) : 8'(p);
      mag3 = {2'b00, mag} + {1'b0, mag, 1'b0};
      q    = mag3[9:2];
      return p[7] ? 8'(-q) : 8'(q);
   endfunction

endpackage

/* src/emc_csr.sv */
module emc_csr
   import emc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data,
   output cfg_type     cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;
   logic [6:0] power_raw;

   assign csr_ready = 1'b1;
   assign power_raw = csr_data[6:0];
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_POWER_LIMIT:  cfg_in.power_limit = (power_raw > PowerMax) ? PowerMax : power_raw;
            CSR_STALL_WINDOW: cfg_in.stall_window_ms = csr_data;
            CSR_MOVE_TIMEOUT: cfg_in.move_timeout_ms = csr_data;
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.power_limit     <= PowerLimitRst;
         cfg_ff.stall_window_ms <= StallWindowRst;
         cfg_ff.move_timeout_ms <= MoveTimeoutRst;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

/* src/emc_step.sv */
module emc_step
   import emc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       fire,
   input  item_type   item,
   input  cfg_type    cfg,
   output result_type result
);

   logic [14:0]       goal_left_ff, goal_right_ff, goal_left_in, goal_right_in;
   logic signed [7:0] drive_left_ff, drive_right_ff, drive_left_in, drive_right_in;
   logic signed [7:0] applied_left_ff, applied_right_ff, applied_left_in, applied_right_in;
   logic [15:0]       prev_left_ff, prev_right_ff, prev_left_in, prev_right_in;
   logic              prev_valid_ff, prev_valid_in;
   logic              stall_pending_ff, stall_pending_in;
   logic              stall_seen_ff, stall_seen_in;
   logic [31:0]       stall_deadline_ff, stall_deadline_in;
   logic [31:0]       move_deadline_ff, move_deadline_in;
   logic              forced_ff, forced_in;
   logic              active_ff, active_in;

   // Start decode.
   logic [15:0]       neg_tl, neg_tr;
   logic [14:0]       start_goal_l, start_goal_r;
   logic signed [7:0] pos_power, neg_power;

   // Sample decode.
   logic              enc_same;
   logic [31:0]       stall_deadline_nx;
   logic              stall_seen_nx;
   logic [3:0]        mask;
   logic              blk;
   logic              done_l, done_r;
   logic signed [7:0] drive_l_nx, drive_r_nx, sl, sr;
   logic [15:0]       nl, nr;
   logic [14:0]       dl, dr;
   logic [30:0]       prod_l, prod_r;

   assign neg_tl = 16'(-item.target_left);
   assign neg_tr = 16'(-item.target_right);
   assign start_goal_l = !item.target_left[15] ? item.target_left[14:0] :
                         (neg_tl[15] ? GoalMax : neg_tl[14:0]);
   assign start_goal_r = !item.target_right[15] ? item.target_right[14:0] :
                         (neg_tr[15] ? GoalMax : neg_tr[14:0]);
   assign pos_power = {1'b0, cfg.power_limit};
   assign neg_power = 8'(-pos_power);

   assign enc_same = prev_valid_ff && (item.enc_left == prev_left_ff)
                     && (item.enc_right == prev_right_ff);
   assign stall_deadline_nx = (enc_same && !stall_pending_ff) ?
                              item.now_ms + {16'h0000, cfg.stall_window_ms} : stall_deadline_ff;
   assign stall_seen_nx = stall_seen_ff
                          | (enc_same && time_reached(item.now_ms, stall_deadline_nx));

   // A bumper blocks when its motor was last driven toward it.
   assign mask[BUMP_RIGHT_REAR]  = item.bumpers[BUMP_RIGHT_REAR] && applied_right_ff[7];
   assign mask[BUMP_LEFT_REAR]   = item.bumpers[BUMP_LEFT_REAR] && applied_left_ff[7];
   assign mask[BUMP_RIGHT_FRONT] = item.bumpers[BUMP_RIGHT_FRONT] && !applied_right_ff[7]
                                   && (applied_right_ff != 8'sd0);
   assign mask[BUMP_LEFT_FRONT]  = item.bumpers[BUMP_LEFT_FRONT] && !applied_left_ff[7]
                                   && (applied_left_ff != 8'sd0);
   assign blk = |mask;

   assign done_l = item.enc_left >= {1'b0, goal_left_ff};
   assign done_r = item.enc_right >= {1'b0, goal_right_ff};
   assign drive_l_nx = done_l ? 8'sd0 : drive_left_ff;
   assign drive_r_nx = done_r ? 8'sd0 : drive_right_ff;

   // Progress ratios compared by cross-multiplication; a zero goal counts as one.
   assign nl = (goal_left_ff != 15'd0) ? item.enc_left : 16'd1;
   assign dl = (goal_left_ff != 15'd0) ? goal_left_ff : 15'd1;
   assign nr = (goal_right_ff != 15'd0) ? item.enc_right : 16'd1;
   assign dr = (goal_right_ff != 15'd0) ? goal_right_ff : 15'd1;
   assign prod_l = {15'd0, nl} * {16'd0, dr};
   assign prod_r = {15'd0, nr} * {16'd0, dl};
   assign sl = (prod_l > prod_r) ? three_quarters(drive_l_nx) : drive_l_nx;
   assign sr = (prod_l > prod_r) ? drive_r_nx : three_quarters(drive_r_nx);

   always_comb begin
      goal_left_in      = goal_left_ff;
      goal_right_in     = goal_right_ff;
      drive_left_in     = drive_left_ff;
      drive_right_in    = drive_right_ff;
      applied_left_in   = applied_left_ff;
      applied_right_in  = applied_right_ff;
      prev_left_in      = prev_left_ff;
      prev_right_in     = prev_right_ff;
      prev_valid_in     = prev_valid_ff;
      stall_pending_in  = stall_pending_ff;
      stall_seen_in     = stall_seen_ff;
      stall_deadline_in = stall_deadline_ff;
      move_deadline_in  = move_deadline_ff;
      forced_in         = forced_ff;
      active_in         = active_ff;

      result.power_left  = 8'sd0;
      result.power_right = 8'sd0;
      result.status      = ST_IDLE;
      result.stalled     = stall_seen_ff;
      result.blocked     = 1'b0;
      result.block_mask  = 4'd0;

      if (fire) begin
         if (item.cmd == CMD_START) begin
            goal_left_in     = start_goal_l;
            goal_right_in    = start_goal_r;
            drive_left_in    = item.target_left[15] ? neg_power : pos_power;
            drive_right_in   = item.target_right[15] ? neg_power : pos_power;
            forced_in        = item.force_req;
            move_deadline_in = item.now_ms + {16'h0000, cfg.move_timeout_ms};
            prev_valid_in    = 1'b0;
            stall_pending_in = 1'b0;
            stall_seen_in    = 1'b0;
            active_in        = 1'b1;
            result.power_left  = applied_left_ff;
            result.power_right = applied_right_ff;
            result.status      = ST_MOVING;
            result.stalled     = 1'b0;
         end else if (!active_ff) begin
            result.status = ST_IDLE;
         end else if (item.stop_request) begin
            applied_left_in  = 8'sd0;
            applied_right_in = 8'sd0;
            active_in        = 1'b0;
            result.status    = ST_STOPPED;
         end else begin
            prev_left_in      = item.enc_left;
            prev_right_in     = item.enc_right;
            prev_valid_in     = 1'b1;
            stall_pending_in  = enc_same;
            stall_deadline_in = stall_deadline_nx;
            stall_seen_in     = stall_seen_nx;
            result.stalled    = stall_seen_nx;
            result.blocked    = blk;
            result.block_mask = mask;
            if ((stall_seen_nx || blk) && !forced_ff) begin
               applied_left_in  = 8'sd0;
               applied_right_in = 8'sd0;
               active_in        = 1'b0;
               result.status    = ST_ABORTED;
            end else if ((stall_seen_nx || blk) && time_reached(item.now_ms, move_deadline_ff)) begin
               applied_left_in  = 8'sd0;
               applied_right_in = 8'sd0;
               active_in        = 1'b0;
               result.status    = ST_TIMEOUT;
            end else begin
               drive_left_in  = drive_l_nx;
               drive_right_in = drive_r_nx;
               if (done_l && done_r) begin
                  applied_left_in  = 8'sd0;
                  applied_right_in = 8'sd0;
                  active_in        = 1'b0;
                  result.status    = ST_REACHED;
               end else begin
                  applied_left_in    = sl;
                  applied_right_in   = sr;
                  result.power_left  = sl;
                  result.power_right = sr;
                  result.status      = ST_MOVING;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         goal_left_ff      <= '0;
         goal_right_ff     <= '0;
         drive_left_ff     <= '0;
         drive_right_ff    <= '0;
         applied_left_ff   <= '0;
         applied_right_ff  <= '0;
         prev_left_ff      <= '0;
         prev_right_ff     <= '0;
         prev_valid_ff     <= 1'b0;
         stall_pending_ff  <= 1'b0;
         stall_seen_ff     <= 1'b0;
         stall_deadline_ff <= '0;
         move_deadline_ff  <= '0;
         forced_ff         <= 1'b0;
         active_ff         <= 1'b0;
      end else begin
         goal_left_ff      <= goal_left_in;
         goal_right_ff     <= goal_right_in;
         drive_left_ff     <= drive_left_in;
         drive_right_ff    <= drive_right_in;
         applied_left_ff   <= applied_left_in;
         applied_right_ff  <= applied_right_in;
         prev_left_ff      <= prev_left_in;
         prev_right_ff     <= prev_right_in;
         prev_valid_ff     <= prev_valid_in;
         stall_pending_ff  <= stall_pending_in;
         stall_seen_ff     <= stall_seen_in;
         stall_deadline_ff <= stall_deadline_in;
         move_deadline_ff  <= move_deadline_in;
         forced_ff         <= forced_in;
         active_ff         <= active_in;
      end
   end

endmodule

/* src/encoder_move_controller.sv */
// Move controller for a two-wheel differential drive.
// The req_ channel takes one beat per item. req_tuser carries the command:
// a start beat loads signed tick targets and the force flag, a sample beat
// brings encoder counts, bumpers, the millisecond clock and the stop button.
// Every accepted beat yields exactly one rsp_ beat with both motor powers,
// the move status, the sticky stall flag and the blocking bumper mask.
// The csr_ channel writes power_limit (index 0), stall_window_ms (index 1)
// and move_timeout_ms (index 2); it is always ready and should only be used
// while no item is in flight.
// An accepted req_ beat is held in the input register while the controller
// step runs in one pass of logic, and the result register captures its
// result, which raises rsp_tvalid. Throughput is one beat per cycle while
// rsp_tready stays high, set by that single-pass step between the two
// registers. Reset clears the valid flags of both registers, puts the
// controller idle and restores the register defaults. When the receiver
// stalls, the result register holds its beat and the input register still
// takes one more beat before req_tready drops.
module encoder_move_controller
   import emc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   // req_tdata, from bit 0 up: target_left[15:0], target_right[15:0],
   // force_req, enc_left[15:0], enc_right[15:0], bumpers[3:0], now_ms[31:0],
   // stop_request, two unused bits.
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [103:0] req_tdata,
   input  logic         req_tuser,   // cmd
   // rsp_tdata, from bit 0 up: power_left[7:0], power_right[7:0], status[2:0],
   // stalled, blocked, block_mask[3:0], seven zero bits.
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [31:0]  rsp_tdata,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [1:0]   csr_index,
   input  logic [15:0]  csr_data
);

   cfg_type    cfg;
   item_type   req_item;
   item_type   item_ff;
   logic       in_valid_ff;
   result_type step_result;
   result_type rsp_result_ff;
   logic       rsp_valid_ff;
   logic       out_free;
   logic       fire;

   // Unpack the request beat into its fields.
   assign req_item.cmd          = req_tuser;
   assign req_item.target_left  = req_tdata[15:0];
   assign req_item.target_right = req_tdata[31:16];
   assign req_item.force_req    = req_tdata[32];
   assign req_item.enc_left     = req_tdata[48:33];
   assign req_item.enc_right    = req_tdata[64:49];
   assign req_item.bumpers      = req_tdata[68:65];
   assign req_item.now_ms       = req_tdata[100:69];
   assign req_item.stop_request = req_tdata[101];

   // The result register frees up when it is empty or being drained.
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign fire       = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || out_free;

   emc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   emc_step u_step (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .item   (item_ff),
      .cfg    (cfg),
      .result (step_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         item_ff <= req_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= fire;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_result_ff <= step_result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'b0000000, rsp_result_ff.block_mask, rsp_result_ff.blocked,
                        rsp_result_ff.stalled, rsp_result_ff.status,
                        rsp_result_ff.power_right, rsp_result_ff.power_left};

endmodule

/* src/emc_checker.sv */
module emc_props
   import emc_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata
);

   // A stalled result beat keeps its contents.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result beat changed while stalled");

   // Any status other than moving comes with both motors off.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[18:16] != ST_MOVING)
      |-> (rsp_tdata[7:0] == 8'd0) && (rsp_tdata[15:8] == 8'd0))
      else $error("power driven on a finished or idle result");

   // The blocked flag is exactly the reduction of the mask.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[20] == (rsp_tdata[24:21] != 4'd0)))
      else $error("blocked flag disagrees with mask");

   // Idle and stop results never read the bumpers.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && ((rsp_tdata[18:16] == ST_IDLE) || (rsp_tdata[18:16] == ST_STOPPED))
      |-> (rsp_tdata[24:20] == 5'd0))
      else $error("bumper report on idle or stopped result");

   // Reset empties the result register.
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

endmodule

bind encoder_move_controller emc_props u_emc_props (.*);
